/* design/rppf_pkg.sv */
// Shared types and codes for the repeating pulse pattern finder.
// Depends on nothing; imported by every other design file.
`default_nettype none

package rppf_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Result kinds
    localparam logic RES_SEARCH = 1'b0;
    localparam logic RES_READ   = 1'b1;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_TOLERANCE = 2'd0;
    localparam logic [1:0] REG_MIN_APP   = 2'd1;
    localparam logic [1:0] REG_LOOKAHEAD = 2'd2;

    // Register reset values
    localparam logic [9:0] TOLERANCE_RST = 10'd75;
    localparam logic [7:0] MIN_APP_RST   = 8'd2;
    localparam logic [3:0] LOOKAHEAD_RST = 4'd5;

    typedef struct packed {
        logic [9:0] match_tolerance;
        logic [7:0] min_appearances;
        logic [3:0] lookahead_pairs;
    } cfg_t;

    // Datapath operations, one per sequencer step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_RDL,
        OP_RDA,
        OP_RDW,
        OP_INIT,
        OP_CAND,
        OP_GAP,
        OP_LA,
        OP_LAC,
        OP_LIST,
        OP_LISTC,
        OP_SJ,
        OP_SJ0,
        OP_SJ1,
        OP_SK,
        OP_SKC,
        OP_SEND,
        OP_BJ,
        OP_BJ0,
        OP_BJ1,
        OP_BK,
        OP_BK0,
        OP_BK1,
        OP_BW,
        OP_BWC
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic cand_ok;
        logic la_done;
        logic la_fail;
        logic list_more;
        logic j_more;
        logic k_more;
        logic len_match;
        logic spacing_fail;
        logic have;
        logic bw_done;
        logic bw_close;
    } sts_t;

endpackage

`default_nettype wire

/* design/rppf_ctrl.sv */
// Sequencer for the pulse pattern finder: accepts items and steps the search.
// Depends on rppf_pkg; drives rppf_dp through cmd_t and reads sts_t.
`default_nettype none

module rppf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    kind,
    input  logic          last_entry,
    input  logic          out_free,
    input  rppf_pkg::sts_t sts,
    output logic          in_ready,
    output logic          out_load,
    output rppf_pkg::cmd_t cmd
);
    import rppf_pkg::*;

    typedef enum logic [24:0] {
        S_IDLE  = 25'h0000001,
        S_INIT  = 25'h0000002,
        S_CAND  = 25'h0000004,
        S_GAP   = 25'h0000008,
        S_LA    = 25'h0000010,
        S_LAC   = 25'h0000020,
        S_LIST  = 25'h0000040,
        S_LISTC = 25'h0000080,
        S_SJ    = 25'h0000100,
        S_SJ0   = 25'h0000200,
        S_SJ1   = 25'h0000400,
        S_SK    = 25'h0000800,
        S_SKC   = 25'h0001000,
        S_SEND  = 25'h0002000,
        S_BJ    = 25'h0004000,
        S_BJ0   = 25'h0008000,
        S_BJ1   = 25'h0010000,
        S_BK    = 25'h0020000,
        S_BK0   = 25'h0040000,
        S_BK1   = 25'h0080000,
        S_BW    = 25'h0100000,
        S_BWC   = 25'h0200000,
        S_RDA   = 25'h0400000,
        S_RDW   = 25'h0800000,
        S_OUT   = 25'h1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        KIND_LOAD:
                        begin
                            cmd.op = OP_LOAD;
                            if (last_entry)
                                state_next = S_INIT;
                        end
                        KIND_READ:
                        begin
                            cmd.op     = OP_RDL;
                            state_next = S_RDA;
                        end
                        KIND_CLEAR: cmd.op = OP_CLEAR;
                        default:    cmd.op = OP_NONE;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_CAND;
            end
            S_CAND:
            begin
                cmd.op     = OP_CAND;
                state_next = sts.cand_ok ? S_GAP : S_OUT;
            end
            S_GAP:
            begin
                cmd.op     = OP_GAP;
                state_next = S_LA;
            end
            S_LA:
            begin
                cmd.op     = OP_LA;
                state_next = sts.la_done ? S_LIST : S_LAC;
            end
            S_LAC:
            begin
                cmd.op     = OP_LAC;
                state_next = sts.la_fail ? S_CAND : S_LA;
            end
            S_LIST:
            begin
                cmd.op     = OP_LIST;
                state_next = sts.list_more ? S_LISTC : S_SJ;
            end
            S_LISTC:
            begin
                cmd.op     = OP_LISTC;
                state_next = S_LIST;
            end
            S_SJ:
            begin
                cmd.op     = OP_SJ;
                state_next = sts.j_more ? S_SJ0 : S_SEND;
            end
            S_SJ0:
            begin
                cmd.op     = OP_SJ0;
                state_next = S_SJ1;
            end
            S_SJ1:
            begin
                cmd.op     = OP_SJ1;
                state_next = sts.len_match ? S_SJ : S_SK;
            end
            S_SK:
            begin
                cmd.op     = OP_SK;
                state_next = sts.k_more ? S_SKC : S_SJ;
            end
            S_SKC:
            begin
                cmd.op     = OP_SKC;
                state_next = S_SK;
            end
            S_SEND:
            begin
                cmd.op     = OP_SEND;
                state_next = sts.spacing_fail ? S_OUT : S_BJ;
            end
            S_BJ:
            begin
                cmd.op     = OP_BJ;
                state_next = sts.j_more ? S_BJ0 : S_OUT;
            end
            S_BJ0:
            begin
                cmd.op     = OP_BJ0;
                state_next = S_BJ1;
            end
            S_BJ1:
            begin
                cmd.op     = OP_BJ1;
                state_next = (sts.len_match && sts.have) ? S_BK : S_BJ;
            end
            S_BK:
            begin
                cmd.op     = OP_BK;
                state_next = sts.k_more ? S_BK0 : S_BJ;
            end
            S_BK0:
            begin
                cmd.op     = OP_BK0;
                state_next = S_BK1;
            end
            S_BK1:
            begin
                cmd.op     = OP_BK1;
                state_next = sts.len_match ? S_BW : S_BK;
            end
            S_BW:
            begin
                cmd.op     = OP_BW;
                state_next = sts.bw_done ? S_BK : S_BWC;
            end
            S_BWC:
            begin
                cmd.op     = OP_BWC;
                state_next = sts.bw_close ? S_BW : S_BK;
            end
            S_RDA:
            begin
                cmd.op     = OP_RDA;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                cmd.op     = OP_RDW;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* design/rppf_dp.sv */
// Datapath of the pulse pattern finder: duration store, start list, counters.
// Depends on rppf_pkg; steered by rppf_ctrl through cmd_t, reports sts_t.
`default_nettype none

module rppf_dp #(
    parameter int BUFFER_PAIRS  = 256,
    parameter int DURATION_BITS = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rppf_pkg::cmd_t cmd,
    input  rppf_pkg::cfg_t cfg,
    input  logic [23:0]    duration,
    input  logic [8:0]     word_index,
    output rppf_pkg::sts_t sts,
    output logic           res_kind,
    output logic           res_found,
    output logic [9:0]     res_length,
    output logic [23:0]    res_word
);
    import rppf_pkg::*;

    localparam int SW  = 2 * BUFFER_PAIRS;
    localparam int AW  = $clog2(SW);
    localparam int CW  = AW + 1;
    localparam int CEW = CW + 1;
    localparam int LW  = $clog2(BUFFER_PAIRS);
    localparam int NW  = LW + 1;
    localparam int DW  = DURATION_BITS;
    localparam int RW  = ((AW > 9) ? AW : 9) + 1;
    localparam int XW  = ((NW > 8) ? NW : 8);
    localparam logic [31:0] DUR_MAX = 32'((64'd1 << DW) - 64'd1);

    logic [DW-1:0] dur_mem [SW];
    logic [AW-1:0] start_mem [BUFFER_PAIRS];

    logic [DW-1:0] rda_reg, rdb_reg;
    logic [AW-1:0] lrd_reg;
    logic [AW-1:0] addr_a, addr_b;
    logic [LW-1:0] laddr;

    logic [CW-1:0] entry_count_reg;
    logic [AW-1:0] fl_reg, ps_reg;
    logic [CW-1:0] cand_reg, k_reg;
    logic [DW-1:0] gap_reg, cw0_reg, res_word_reg;
    logic [3:0]    i_reg;
    logic [NW-1:0] lcnt_reg, j_reg, best_app_reg, app_reg;
    logic [AW-1:0] best_len_reg, cur_len_reg, lprev_reg, jstart_reg;
    logic [AW-1:0] best_start_reg, bi_reg;
    logic          have_reg, res_kind_reg;
    logic [8:0]    widx_reg;

    logic          dwr_en, lwr_en, pair_match, store_room;
    logic [31:0]   dur32, dur_sat;
    logic [AW-1:0] ldiff;
    logic          in_range, raddr_ok;
    logic [RW-1:0] sum2, off, raddr_w;

    function automatic logic close_f(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                     input logic [9:0] t);
        logic [DW-1:0] d;
        d = (x > y) ? (x - y) : (y - x);
        return d < DW'(t);
    endfunction

    // Status toward the sequencer
    assign ldiff      = lrd_reg - lprev_reg;
    assign pair_match = close_f(cw0_reg, rda_reg, cfg.match_tolerance)
                     && close_f(gap_reg, rdb_reg, cfg.match_tolerance);
    assign store_room = entry_count_reg < CW'(SW);

    always_comb
    begin
        sts.cand_ok      = (CEW'(cand_reg) + CEW'(1) + (CEW'(cfg.lookahead_pairs) << 1))
                         < CEW'(entry_count_reg);
        sts.la_done      = i_reg >= cfg.lookahead_pairs;
        sts.la_fail      = (rda_reg > gap_reg)
                        || close_f(gap_reg, rda_reg, cfg.match_tolerance);
        sts.list_more    = (CEW'(k_reg) + CEW'(1)) < CEW'(entry_count_reg);
        sts.j_more       = (CEW'(j_reg) + CEW'(1)) < CEW'(lcnt_reg);
        sts.k_more       = (CEW'(k_reg) + CEW'(1)) < CEW'(lcnt_reg);
        sts.len_match    = ldiff == best_len_reg;
        sts.spacing_fail = XW'(best_app_reg) < XW'(cfg.min_appearances);
        sts.have         = have_reg;
        sts.bw_done      = bi_reg >= best_len_reg;
        sts.bw_close     = close_f(rda_reg, rdb_reg, cfg.match_tolerance);
    end

    // Read item: rotate by two inside the held pattern
    always_comb
    begin
        in_range = RW'(widx_reg) < RW'(fl_reg);
        sum2     = RW'(widx_reg) + RW'(2);
        if (fl_reg == AW'(1))
            off = '0;
        else if (sum2 >= RW'(fl_reg))
            off = sum2 - RW'(fl_reg);
        else
            off = sum2;
        raddr_w  = RW'(ps_reg) + off;
        raddr_ok = raddr_w < RW'(SW);
    end

    // Store addresses
    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        laddr  = '0;
        unique case (cmd.op)
            OP_CAND:
            begin
                addr_a = AW'(cand_reg + CW'(1));
                addr_b = AW'(cand_reg);
            end
            OP_LA:    addr_a = AW'(cand_reg + (CW'(i_reg) << 1) + CW'(1));
            OP_LIST:
            begin
                addr_a = AW'(k_reg);
                addr_b = AW'(k_reg + CW'(1));
            end
            OP_BW:
            begin
                addr_a = jstart_reg + bi_reg;
                addr_b = lprev_reg + bi_reg;
            end
            OP_RDA:   addr_a = AW'(raddr_w);
            OP_SJ:    laddr  = LW'(j_reg);
            OP_SJ0:   laddr  = LW'(j_reg + NW'(1));
            OP_SK:    laddr  = LW'(k_reg + CW'(1));
            OP_BJ:    laddr  = LW'(j_reg);
            OP_BJ0:   laddr  = LW'(j_reg + NW'(1));
            OP_BK:    laddr  = LW'(k_reg);
            OP_BK0:   laddr  = LW'(k_reg + CW'(1));
            default:  addr_a = '0;
        endcase
    end

    // Saturate wide durations
    assign dur32   = 32'(duration);
    assign dur_sat = (dur32 > DUR_MAX) ? DUR_MAX : dur32;
    assign dwr_en  = (cmd.op == OP_LOAD) && store_room;
    assign lwr_en  = (cmd.op == OP_LISTC) && pair_match && (lcnt_reg < NW'(BUFFER_PAIRS));

    always_ff @(posedge clk)
    begin
        if (dwr_en)
            dur_mem[AW'(entry_count_reg)] <= DW'(dur_sat);
        rda_reg <= dur_mem[addr_a];
        rdb_reg <= dur_mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (lwr_en)
            start_mem[LW'(lcnt_reg)] <= AW'(k_reg);
        lrd_reg <= start_mem[laddr];
    end

    // Held state: entry count and found pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            fl_reg          <= '0;
            ps_reg          <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LOAD:
                begin
                    if (store_room)
                        entry_count_reg <= entry_count_reg + CW'(1);
                end
                OP_CLEAR: entry_count_reg <= '0;
                OP_INIT:
                begin
                    fl_reg <= '0;
                    ps_reg <= '0;
                end
                OP_BJ:
                begin
                    if (!sts.j_more && have_reg)
                    begin
                        fl_reg <= best_len_reg;
                        ps_reg <= best_start_reg;
                    end
                end
                default: fl_reg <= fl_reg;
            endcase
        end
    end

    // Search working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_RDL: widx_reg <= word_index;
            OP_INIT:
            begin
                cand_reg     <= CW'((entry_count_reg >> 2) << 1);
                res_kind_reg <= RES_SEARCH;
                res_word_reg <= '0;
            end
            OP_GAP:
            begin
                gap_reg <= rda_reg;
                cw0_reg <= rdb_reg;
                i_reg   <= 4'd1;
            end
            OP_LA:
            begin
                if (sts.la_done)
                begin
                    k_reg    <= '0;
                    lcnt_reg <= '0;
                end
            end
            OP_LAC:
            begin
                if (sts.la_fail)
                    cand_reg <= cand_reg + CW'(2);
                else
                    i_reg <= i_reg + 4'd1;
            end
            OP_LIST:
            begin
                if (!sts.list_more)
                begin
                    j_reg        <= '0;
                    best_len_reg <= '0;
                    best_app_reg <= '0;
                end
            end
            OP_LISTC:
            begin
                if (lwr_en)
                    lcnt_reg <= lcnt_reg + NW'(1);
                k_reg <= k_reg + CW'(2);
            end
            OP_SJ0: lprev_reg <= lrd_reg;
            OP_SJ1:
            begin
                lprev_reg <= lrd_reg;
                if (sts.len_match)
                    j_reg <= j_reg + NW'(1);
                else
                begin
                    cur_len_reg <= ldiff;
                    app_reg     <= NW'(1);
                    k_reg       <= CW'(j_reg) + CW'(1);
                end
            end
            OP_SK:
            begin
                if (!sts.k_more)
                begin
                    if (app_reg > best_app_reg)
                    begin
                        best_app_reg <= app_reg;
                        best_len_reg <= cur_len_reg;
                    end
                    j_reg <= j_reg + NW'(1);
                end
            end
            OP_SKC:
            begin
                lprev_reg <= lrd_reg;
                if (ldiff == cur_len_reg)
                    app_reg <= app_reg + NW'(1);
                k_reg <= k_reg + CW'(1);
            end
            OP_SEND:
            begin
                j_reg        <= '0;
                have_reg     <= 1'b0;
                best_app_reg <= '0;
            end
            OP_BJ0: lprev_reg <= lrd_reg;
            OP_BJ1:
            begin
                if (!sts.len_match)
                    j_reg <= j_reg + NW'(1);
                else if (!have_reg)
                begin
                    have_reg       <= 1'b1;
                    best_start_reg <= lprev_reg;
                    j_reg          <= j_reg + NW'(1);
                end
                else
                begin
                    jstart_reg <= lprev_reg;
                    app_reg    <= '0;
                    k_reg      <= '0;
                end
            end
            OP_BK:
            begin
                if (!sts.k_more)
                begin
                    if (app_reg > best_app_reg)
                    begin
                        best_app_reg   <= app_reg;
                        best_start_reg <= jstart_reg;
                    end
                    j_reg <= j_reg + NW'(1);
                end
            end
            OP_BK0: lprev_reg <= lrd_reg;
            OP_BK1:
            begin
                if (!sts.len_match)
                    k_reg <= k_reg + CW'(1);
                else
                    bi_reg <= '0;
            end
            OP_BW:
            begin
                if (sts.bw_done)
                begin
                    app_reg <= app_reg + NW'(1);
                    k_reg   <= k_reg + CW'(1);
                end
            end
            OP_BWC:
            begin
                if (!sts.bw_close)
                    k_reg <= k_reg + CW'(1);
                else
                    bi_reg <= bi_reg + AW'(1);
            end
            OP_RDW:
            begin
                res_kind_reg <= RES_READ;
                res_word_reg <= (in_range && raddr_ok) ? rda_reg : '0;
            end
            default: have_reg <= have_reg;
        endcase
    end

    assign res_kind   = res_kind_reg;
    assign res_found  = fl_reg != '0;
    assign res_length = 10'(fl_reg);
    assign res_word   = 24'(32'(res_word_reg));

endmodule

`default_nettype wire

/* design/repeating_pulse_pattern_finder.sv */
// Loads other than the last, and clear items, leave the sequencer idle, so such loads
// stream at one per cycle. A read item passes through the RDA and RDW states to the
// output state, and its result is loaded into the output register once that is free.
// A search after the last load checks candidates with lookahead, scans the list,
// counts spacings and compares blobs. Reset clears the entry count, found pattern
// and configuration registers; the store itself is not cleared.
// Top level: APB register file, output register, sequencer and datapath.
// Depends on rppf_pkg, rppf_ctrl and rppf_dp.
`default_nettype none

module repeating_pulse_pattern_finder #(
    parameter int BUFFER_PAIRS  = 256,
    parameter int DURATION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [23:0] duration,
    input  logic        last_entry,
    input  logic [8:0]  word_index,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic        found,
    output logic [9:0]  pattern_length,
    output logic [23:0] pattern_word,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rppf_pkg::*;

    cfg_t        cfg_reg;
    cmd_t        cmd;
    sts_t        sts;
    logic        out_load, out_free;
    logic        res_kind, res_found;
    logic [9:0]  res_length;
    logic [23:0] res_word;

    logic        out_valid_reg;
    logic        result_kind_reg, found_reg;
    logic [9:0]  pattern_length_reg;
    logic [23:0] pattern_word_reg;

    // Configuration registers: write on the access phase, no wait states
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_tolerance <= TOLERANCE_RST;
            cfg_reg.min_appearances <= MIN_APP_RST;
            cfg_reg.lookahead_pairs <= LOOKAHEAD_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_TOLERANCE: cfg_reg.match_tolerance <= pwdata[9:0];
                REG_MIN_APP:   cfg_reg.min_appearances <= pwdata[7:0];
                REG_LOOKAHEAD: cfg_reg.lookahead_pairs <= pwdata[3:0];
                default:       cfg_reg.lookahead_pairs <= cfg_reg.lookahead_pairs;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TOLERANCE: prdata = 32'(cfg_reg.match_tolerance);
            REG_MIN_APP:   prdata = 32'(cfg_reg.min_appearances);
            REG_LOOKAHEAD: prdata = 32'(cfg_reg.lookahead_pairs);
            default:       prdata = '0;
        endcase
    end

    // Output register frees as soon as the held item is taken
    assign out_free = !out_valid_reg || out_ready;

    rppf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .kind       (kind),
        .last_entry (last_entry),
        .out_free   (out_free),
        .sts        (sts),
        .in_ready   (in_ready),
        .out_load   (out_load),
        .cmd        (cmd)
    );

    rppf_dp #(
        .BUFFER_PAIRS  (BUFFER_PAIRS),
        .DURATION_BITS (DURATION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .duration   (duration),
        .word_index (word_index),
        .sts        (sts),
        .res_kind   (res_kind),
        .res_found  (res_found),
        .res_length (res_length),
        .res_word   (res_word)
    );

    // Hold the result until taken; load a new one when the sequencer finishes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_kind_reg    <= res_kind;
            found_reg          <= res_found;
            pattern_length_reg <= res_length;
            pattern_word_reg   <= res_word;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = result_kind_reg;
    assign found          = found_reg;
    assign pattern_length = pattern_length_reg;
    assign pattern_word   = pattern_word_reg;

endmodule

`default_nettype wire

/* design/rppf_checker.sv */
// Port-level checks for the pulse pattern finder, bound to the top level.
// Depends on rppf_pkg and repeating_pulse_pattern_finder.
`default_nettype none

module rppf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  kind,
    input wire logic        last_entry,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        result_kind,
    input wire logic        found,
    input wire logic [9:0]  pattern_length,
    input wire logic [23:0] pattern_word
);
    import rppf_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pattern_word)
        && $stable(pattern_length) && $stable(result_kind))
        else $error("result changed while stalled");

    // The last load starts a search, so input stalls next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_LOAD && last_entry |=> !in_ready)
        else $error("input taken while search starts");

    // A plain load streams
    a_load_stream: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_LOAD && !last_entry |=> in_ready)
        else $error("plain load stalled input");

    // A search outcome carries no word
    a_search_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_SEARCH |-> pattern_word == 24'd0)
        else $error("search outcome with nonzero word");

    // No pattern means no length and no word
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> pattern_length == 10'd0 && pattern_word == 24'd0)
        else $error("empty pattern reports data");

endmodule

bind repeating_pulse_pattern_finder rppf_checker u_rppf_checker (.*);

`default_nettype wire
